// ===== rtl/amwd_pkg.sv =====
// Package for the accelerometer motion window detector.
// Holds ring and rate constants, config register indexes and the control/status structs.
// No dependencies; every other file of the block imports it.
package amwd_pkg;

  localparam int RingDepth    = 64;
  localparam int SampleRateHz = 256;

  localparam int AxisW   = 16;
  localparam int MagW    = 16;
  localparam int SumW    = 2 * AxisW;
  localparam int CfgW    = 16;
  localparam int PtrW    = $clog2(RingDepth);
  localparam int CntW    = $clog2(RingDepth + 1);
  localparam int CfgIdxW = 1;

  localparam logic [MagW-1:0] OneGCounts = MagW'(4096);

  // Window conversion: below WinCapMs the product window_ms * SampleRateHz stays under
  // RingDepth * 1000, and its quotient by 1000 is a multiply by a rounded-up reciprocal.
  localparam int WinCapMs   = (RingDepth * 1000 + SampleRateHz - 1) / SampleRateHz;
  localparam int ProdW      = $clog2(RingDepth * 1000);
  localparam int RecipShift = ProdW + 10;
  localparam int RecipW     = RecipShift - 9;
  localparam logic [RecipW-1:0] RecipMul = RecipW'(((2 ** RecipShift) + 999) / 1000);

  localparam logic [CfgW-1:0] ThresholdReset = CfgW'(410);
  localparam logic [CfgW-1:0] WindowReset    = CfgW'(250);

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 1'b0,
    CfgWindow    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic sq_load;
    logic root_init;
    logic root_step;
    logic store;
    logic scan_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic root_last;
    logic scan_done;
  } dp_status_t;

endpackage

// ===== rtl/amwd_if.sv =====
// Handshake interfaces for the motion window detector: sample requests in, results out.
// Depends on amwd_pkg for field widths.
interface amwd_in_if import amwd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AxisW-1:0] accel_x;
  logic signed [AxisW-1:0] accel_y;
  logic signed [AxisW-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface amwd_out_if import amwd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [MagW-1:0] magnitude;
  logic            motion_detected;

  modport source (output valid, output magnitude, output motion_detected, input ready);
  modport sink   (input valid, input magnitude, input motion_detected, output ready);
endinterface

// ===== rtl/amwd_ctrl.sv =====
// Sequencer of the motion window detector: walks one request through square root,
// ring store and window scan, and owns the input ready and output valid. Uses amwd_pkg.
module amwd_ctrl import amwd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [5:0] {
    StIdle     = 6'b000001,
    StRootInit = 6'b000010,
    StRoot     = 6'b000100,
    StStore    = 6'b001000,
    StScan     = 6'b010000,
    StOut      = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.sq_load = 1'b1;
          state_d       = StRootInit;
        end
      end
      StRootInit: begin
        cmd_o.root_init = 1'b1;
        state_d         = StRoot;
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        if (status_i.root_last) begin
          state_d = StStore;
        end
      end
      StStore: begin
        cmd_o.store = 1'b1;
        state_d     = StScan;
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/amwd_dp.sv =====
// Datapath of the motion window detector: squares, bit-pair square root, magnitude
// ring memory, window scan and the result register. Driven by amwd_ctrl; uses amwd_pkg.
module amwd_dp import amwd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  input  logic signed [AxisW-1:0] accel_x_i,
  input  logic signed [AxisW-1:0] accel_y_i,
  input  logic signed [AxisW-1:0] accel_z_i,
  input  logic [CfgW-1:0]         threshold_i,
  input  logic [CfgW-1:0]         window_ms_i,
  output logic [MagW-1:0]         magnitude_o,
  output logic                    motion_o
);

  // Squares, one multiplier per axis, registered.
  logic signed [SumW-1:0] xs, ys, zs;
  logic [SumW-1:0] sqx_q, sqy_q, sqz_q;

  assign xs = SumW'(accel_x_i);
  assign ys = SumW'(accel_y_i);
  assign zs = SumW'(accel_z_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_load) begin
      sqx_q <= $unsigned(xs * xs);
      sqy_q <= $unsigned(ys * ys);
      sqz_q <= $unsigned(zs * zs);
    end
  end

  // Restoring square root, one result bit per cycle.
  logic [SumW-1:0] rem_q, res_q, bit_q;
  logic [SumW:0]   trial;
  logic            fits;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign fits  = {1'b0, rem_q} >= trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      rem_q <= sqx_q + sqy_q + sqz_q;
      res_q <= '0;
      bit_q <= SumW'(1) << (SumW - 2);
    end else if (cmd_i.root_step) begin
      if (fits) begin
        rem_q <= rem_q - trial[SumW-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign status_o.root_last = bit_q[0];

  // Window length in samples, capped at the ring depth.
  logic [31:0]              win_prod;
  logic [ProdW+RecipW-1:0]  win_recip;
  logic [CntW-1:0]          win_cfg;

  assign win_prod  = 32'(window_ms_i) * 32'(SampleRateHz);
  assign win_recip = (ProdW+RecipW)'(win_prod[ProdW-1:0]) * (ProdW+RecipW)'(RecipMul);

  always_comb begin
    if (window_ms_i >= CfgW'(WinCapMs)) begin
      win_cfg = CntW'(RingDepth);
    end else begin
      win_cfg = CntW'(win_recip >> RecipShift);
    end
  end

  // Ring pointer and fill count.
  logic [PtrW-1:0] wp_q;
  logic [CntW-1:0] cnt_q, cnt_next;

  assign cnt_next = (cnt_q == CntW'(RingDepth)) ? cnt_q : cnt_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.store) begin
      wp_q  <= (wp_q == PtrW'(RingDepth - 1)) ? '0 : wp_q + PtrW'(1);
      cnt_q <= cnt_next;
    end
  end

  // Scan from the newest entry backwards; one read issued per cycle.
  logic [PtrW-1:0] scan_pos_q;
  logic [CntW-1:0] scan_left_q;
  logic            rd_vld_q, motion_q, issue;
  logic [MagW-1:0] rd_data_q, dev;

  assign issue = cmd_i.scan_step && (scan_left_q != '0) && !motion_q;
  assign dev   = (rd_data_q >= OneGCounts) ? rd_data_q - OneGCounts : OneGCounts - rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      scan_pos_q  <= wp_q;
      scan_left_q <= (win_cfg < cnt_next) ? win_cfg : cnt_next;
      motion_q    <= 1'b0;
    end else begin
      if (issue) begin
        scan_pos_q  <= (scan_pos_q == '0) ? PtrW'(RingDepth - 1) : scan_pos_q - PtrW'(1);
        scan_left_q <= scan_left_q - CntW'(1);
      end
      if (cmd_i.scan_step && rd_vld_q && (dev > threshold_i)) begin
        motion_q <= 1'b1;
      end
    end
  end

  assign status_o.scan_done = !rd_vld_q && ((scan_left_q == '0) || motion_q);

  // Magnitude ring memory.
  logic [MagW-1:0] ring_mem [RingDepth];

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      ring_mem[wp_q] <= res_q[MagW-1:0];
    end
    if (issue) begin
      rd_data_q <= ring_mem[scan_pos_q];
    end
  end

  // Result register.
  logic [MagW-1:0] out_mag_q;
  logic            out_motion_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mag_q    <= res_q[MagW-1:0];
      out_motion_q <= motion_q;
    end
  end

  assign magnitude_o = out_mag_q;
  assign motion_o    = out_motion_q;

endmodule

// ===== rtl/accel_motion_window_detector_top.sv =====
// Top level of the accelerometer motion window detector.
// Instantiates amwd_ctrl and amwd_dp, holds the config registers; uses amwd_pkg and amwd_if.

// Each request carries one raw 3-axis sample (signed 16-bit, 4096 counts per g). The block
// returns one result per request: the floor square root of the summed squares (1/4096 g)
// and a motion flag that is set when any of the most recent W stored magnitudes, the new
// one included, differs from 4096 by more than the threshold. W is window_ms * 256 / 1000,
// capped at the 64-entry ring and at the number of samples stored since reset; a zero
// window never flags motion. Requests are handled one at a time: each request passes
// through the 16-step square root, the ring store and the window scan before its result
// is loaded. The scan reads one ring entry per cycle from a single-port memory and stops
// early at the first deviating entry, which can only shorten it. The result sits in an
// output register, so the next request is taken while a result still waits. Config
// registers (0: threshold_counts, reset 410; 1: window_ms, reset 250) are written through
// cfg_we_i / cfg_idx_i / cfg_data_i and should only change while the block is idle.
module accel_motion_window_detector_top import amwd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  amwd_in_if.sink            sample_i,
  amwd_out_if.source         result_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // Configuration registers.
  logic [CfgW-1:0] threshold_q, window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      window_q    <= WindowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgThreshold: threshold_q <= cfg_data_i;
        CfgWindow:    window_q    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  dp_cmd_t    cmd;
  dp_status_t status;

  // The sequencer accepts a request only when it is idle and keeps the result valid
  // until the sink takes it.
  amwd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // The datapath captures the squares on acceptance, so the sample need not be held.
  amwd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .accel_x_i   (sample_i.accel_x),
    .accel_y_i   (sample_i.accel_y),
    .accel_z_i   (sample_i.accel_z),
    .threshold_i (threshold_q),
    .window_ms_i (window_q),
    .magnitude_o (result_o.magnitude),
    .motion_o    (result_o.motion_detected)
  );

endmodule

// ===== tb/accel_motion_window_detector_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for accel_motion_window_detector_top: a table of directed samples,
// then randomized phases under several register settings. Depends on amwd_pkg and amwd_if.
module accel_motion_window_detector_top_tb;
  import amwd_pkg::*;

  // Run shape: a fixed number of random phases, each with its own register setting.
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 192;
  localparam int PressurePhase = 2;
  // The receiver's long hold-off, long enough to back the block up into its input.
  localparam int LongHold      = 600;
  // Cycles left after the last result before registers change or the run ends.
  localparam int IdleGuard     = 4;
  localparam int DrainCycles   = 120;
  // Quiet cycles on all ports before the run is declared hung.
  localparam int StallLimit    = 4000;
  localparam int MaxReports    = 100;
  localparam int NumRows       = 24;

  typedef struct packed {
    logic signed [AxisW-1:0] x;
    logic signed [AxisW-1:0] y;
    logic signed [AxisW-1:0] z;
  } accel_t;

  typedef struct packed {
    logic [MagW-1:0] magnitude;
    logic            motion;
  } outcome_t;

  typedef enum logic {
    RowSample,
    RowWrite
  } row_kind_e;

  // One line of the directed table. A sample row either carries its outcome typed in
  // (given set) or leaves it to the predictor; a write row changes one register.
  typedef struct packed {
    row_kind_e       kind;
    cfg_idx_e        reg_sel;
    logic [CfgW-1:0] cfg_val;
    accel_t          sample;
    logic            given;
    outcome_t        outcome;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  amwd_in_if  sample_if ();
  amwd_out_if result_if ();

  accel_motion_window_detector_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state: a private copy of the magnitude ring and of both registers.
  logic [MagW-1:0] mag_ring [RingDepth];
  logic [PtrW-1:0] ring_wr;
  logic [CntW-1:0] ring_fill;
  logic [CfgW-1:0] thr_reg;
  logic [CfgW-1:0] win_ms_reg;

  outcome_t awaited_outcomes [$];
  int       fail_count;
  int       quiet_cycles;
  logic     hold_req;

  // Directed table. The first rows run on the reset setting; the window is then swept through
  // zero, its cap, the 0/1 boundary (3 ms gives no entry, 4 ms gives one) and 63/64 entries.
  row_t directed_rows [NumRows] = '{
    // Right after reset the window (64) exceeds the stored samples, so only those are scanned.
    '{RowSample, CfgThreshold, 16'h0, '{16'h0000, 16'h0000, 16'h1000}, 1'b1, '{16'd4096, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h1000, 16'h0000, 16'h0000}, 1'b1, '{16'd4096, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h0000, 16'hF000, 16'h0000}, 1'b1, '{16'd4096, 1'b0}},
    // Full-scale negative and positive on all three axes.
    '{RowSample, CfgThreshold, 16'h0, '{16'h8000, 16'h8000, 16'h8000}, 1'b1, '{16'd56755, 1'b1}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1, '{16'd56754, 1'b1}},
    // A zero window never flags motion, not even for free fall.
    '{RowWrite,  CfgWindow,    16'h0000, '{16'h0, 16'h0, 16'h0}, 1'b0, '{16'd0, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'd0, 1'b0}},
    // Largest threshold and a window far beyond the ring.
    '{RowWrite,  CfgThreshold, 16'hFFFF, '{16'h0, 16'h0, 16'h0}, 1'b0, '{16'd0, 1'b0}},
    '{RowWrite,  CfgWindow,    16'hFFFF, '{16'h0, 16'h0, 16'h0}, 1'b0, '{16'd0, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'd0, 1'b0}},
    // Zero threshold: the zero magnitudes still in the window trip the flag.
    '{RowWrite,  CfgThreshold, 16'h0000, '{16'h0, 16'h0, 16'h0}, 1'b0, '{16'd0, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h0000, 16'h0000, 16'h1000}, 1'b1, '{16'd4096, 1'b1}},
    '{RowWrite,  CfgWindow,    16'h0003, '{16'h0, 16'h0, 16'h0}, 1'b0, '{16'd0, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'd1, 1'b0}},
    // A one-entry window looks at the new sample alone.
    '{RowWrite,  CfgWindow,    16'h0004, '{16'h0, 16'h0, 16'h0}, 1'b0, '{16'd0, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h1000, 16'h0000, 16'h0000}, 1'b1, '{16'd4096, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h1001, 16'h0000, 16'h0000}, 1'b1, '{16'd4097, 1'b1}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h0000, 16'h0FFF, 16'h0000}, 1'b1, '{16'd4095, 1'b1}},
    '{RowWrite,  CfgWindow,    16'd249,  '{16'h0, 16'h0, 16'h0}, 1'b0, '{16'd0, 1'b0}},
    '{RowWrite,  CfgThreshold, 16'h0001, '{16'h0, 16'h0, 16'h0}, 1'b0, '{16'd0, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h0A00, 16'h0A00, 16'h0A00}, 1'b0, '{16'd0, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h093D, 16'h093D, 16'h093D}, 1'b0, '{16'd0, 1'b0}},
    '{RowWrite,  CfgWindow,    16'd250,  '{16'h0, 16'h0, 16'h0}, 1'b0, '{16'd0, 1'b0}},
    '{RowSample, CfgThreshold, 16'h0, '{16'h0000, 16'h0000, 16'hF000}, 1'b0, '{16'd0, 1'b0}}
  };

  // Digit-by-digit integer square root, floor of the exact root.
  function automatic logic [MagW-1:0] floor_root(longint unsigned energy);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = energy;
    root  = 0;
    probe = 64'h1 << 62;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return MagW'(root);
  endfunction

  // Stores the new magnitude in the ring and scans the most recent window for a deviation
  // from 1 g beyond the threshold. The window never reaches past the samples stored so far.
  function automatic outcome_t magnitude_and_motion(accel_t s);
    longint          sx;
    longint          sy;
    longint          sz;
    int              win;
    logic [PtrW-1:0] pos;
    logic [MagW-1:0] m;
    logic [MagW-1:0] dev;
    outcome_t        r;
    sx = longint'($signed(s.x));
    sy = longint'($signed(s.y));
    sz = longint'($signed(s.z));
    r.magnitude = floor_root(longint'(sx * sx + sy * sy + sz * sz));
    r.motion    = 1'b0;
    mag_ring[ring_wr] = r.magnitude;
    ring_wr = ring_wr + 1'b1;
    if (ring_fill < RingDepth) ring_fill = ring_fill + 1'b1;
    win = (int'(win_ms_reg) * SampleRateHz) / 1000;
    if (win > RingDepth) win = RingDepth;
    if (win > int'(ring_fill)) win = int'(ring_fill);
    pos = ring_wr;
    for (int i = 0; i < win; i++) begin
      pos = pos - 1'b1;
      m   = mag_ring[pos];
      dev = (m >= OneGCounts) ? m - OneGCounts : OneGCounts - m;
      if (dev > thr_reg) r.motion = 1'b1;
    end
    return r;
  endfunction

  // Mostly near-rest samples, so the threshold decides; some motion, full-range noise
  // and corner values mixed in.
  function automatic accel_t draw_sample();
    int     v [3];
    int     corners [6];
    int     pick;
    int     axis;
    accel_t s;
    corners = '{-32768, 32767, 0, -1, 4096, -4096};
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      for (int a = 0; a < 3; a++) v[a] = int'($urandom_range(0, 1400)) - 700;
      axis = $urandom_range(0, 2);
      v[axis] = 4096 + int'($urandom_range(0, 1200)) - 600;
      if ($urandom_range(0, 1) == 1) v[axis] = -v[axis];
    end else if (pick < 80) begin
      for (int a = 0; a < 3; a++) v[a] = int'($urandom_range(0, 24000)) - 12000;
    end else if (pick < 92) begin
      for (int a = 0; a < 3; a++) v[a] = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      for (int a = 0; a < 3; a++) v[a] = corners[$urandom_range(0, 5)];
    end
    s.x = AxisW'(v[0]);
    s.y = AxisW'(v[1]);
    s.z = AxisW'(v[2]);
    return s;
  endfunction

  // Offers one request and holds it until the block takes it. The outcome is worked out
  // at acceptance; a typed-in outcome, where given, replaces the predicted one.
  task automatic offer_sample(input accel_t s, input logic given, input outcome_t typed);
    outcome_t pred;
    sample_if.valid   <= 1'b1;
    sample_if.accel_x <= s.x;
    sample_if.accel_y <= s.y;
    sample_if.accel_z <= s.z;
    do @(posedge clk_i); while (!sample_if.ready);
    pred = magnitude_and_motion(s);
    awaited_outcomes.push_back(given ? typed : pred);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      sample_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Registers only change with the block idle: every outstanding result has drained.
  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    sample_if.valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (IdleGuard) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgThreshold: thr_reg = val;
      default:      win_ms_reg = val;
    endcase
  endtask

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: segments of random length that are always ready, randomly ready, or ready one
  // cycle in four. A hold-off request takes ready low until the LongHold countdown here runs out.
  initial begin : result_drain
    int seg_left;
    int mode;
    int hold_left;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = LongHold;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(16, 200);
        end
        seg_left--;
        case (mode)
          0:       result_if.ready <= 1'b1;
          1:       result_if.ready <= ($urandom_range(0, 9) < 7);
          default: result_if.ready <= (seg_left % 4 == 0);
        endcase
      end
    end
  end

  // Each accepted result is matched field by field against the oldest outcome waiting.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (awaited_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: result with nothing expected, got magnitude %0d motion %0b",
                   $time, result_if.magnitude, result_if.motion_detected);
      end else begin
        want = awaited_outcomes.pop_front();
        if (result_if.magnitude !== want.magnitude) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: magnitude mismatch, expected %0d, got %0d",
                     $time, want.magnitude, result_if.magnitude);
        end
        if (result_if.motion_detected !== want.motion) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: motion_detected mismatch, expected %0b, got %0b",
                     $time, want.motion, result_if.motion_detected);
        end
      end
    end
  end

  // Hang detection: any handshake or register write counts as progress.
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: timeout, no progress for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int          thr;
    int          win;
    int          sent;
    int          burst;
    logic        steady;
    rst_ni            <= 1'b0;
    sample_if.valid   <= 1'b0;
    sample_if.accel_x <= '0;
    sample_if.accel_y <= '0;
    sample_if.accel_z <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CfgThreshold;
    cfg_data_i        <= '0;
    hold_req          <= 1'b0;
    quiet_cycles      <= 0;
    fail_count   = 0;
    ring_wr      = '0;
    ring_fill    = '0;
    thr_reg      = ThresholdReset;
    win_ms_reg   = WindowReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, with short random gaps between samples.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowWrite) begin
        write_cfg(directed_rows[i].reg_sel, directed_rows[i].cfg_val);
      end else begin
        offer_sample(directed_rows[i].sample, directed_rows[i].given, directed_rows[i].outcome);
        pause_sender($urandom_range(0, 3));
      end
    end

    // Random phases. Each sets both registers; the extremes come back, and one phase
    // provokes a long receiver hold-off while the sender keeps offering.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin thr = 410;                        win = 250;                        end
        1: begin thr = 0;                          win = 4;                          end
        2: begin thr = $urandom_range(200, 700);   win = $urandom_range(20, 250);    end
        3: begin thr = 65535;                      win = 65535;                      end
        4: begin thr = $urandom_range(100, 1500);  win = 249;                        end
        5: begin thr = $urandom_range(0, 65535);   win = $urandom_range(0, 65535);   end
        6: begin thr = 200;                        win = $urandom_range(5, 60);      end
        default: begin thr = $urandom_range(0, 400); win = 0;                        end
      endcase
      write_cfg(CfgThreshold, CfgW'(thr));
      write_cfg(CfgWindow, CfgW'(win));
      if (ph == PressurePhase) hold_req <= 1'b1;
      // The first phase sends back to back with no sender gaps at all.
      steady = (ph == 0);
      sent = 0;
      while (sent < ItemsPerPhase) begin
        burst = $urandom_range(1, 16);
        for (int k = 0; k < burst && sent < ItemsPerPhase; k++) begin
          offer_sample(draw_sample(), 1'b0, '0);
          sent++;
        end
        if (!steady)
          pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
      end
    end

    // Let every result come back, then watch a while longer for anything unexpected.
    sample_if.valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && awaited_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
